FILE: sv/compacting_id_allowlist_top_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the card allowlist
// shared helpers so every checked module writes properties the same way
// ----------------------------------------------------------------------------
`ifndef COMPACTING_ID_ALLOWLIST_TOP_ASSERT_SVH
`define COMPACTING_ID_ALLOWLIST_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allowlist check failed");

// next-cycle implication, disabled while reset is low
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allowlist check failed");

`endif

FILE: sv/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// types, codes and sizes shared by the card allowlist modules
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    // neighbor of the head cell; a one-entry ring wraps onto itself
    localparam int NEXT_IDX    = (MAX_ENTRIES > 1) ? 1 : 0;

    localparam int KIND_W   = 2;
    localparam int ID_W     = 32;
    localparam int TYPE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    localparam logic [ID_W-1:0] ID_NONE     = '0;
    localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_PRESENT   = 3'd2,
        STAT_INVALID   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]   card_id;
        logic [TYPE_W-1:0] card_type;
    } t_rec;

    typedef struct packed {
        t_kind kind;
        t_rec  rec;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               entry_valid;
        t_rec               rec;
        logic [COUNT_W-1:0] entry_count;
        logic               last;
    } t_res;

endpackage

FILE: sv/cia_if.sv
// ----------------------------------------------------------------------------
// cia_if
// valid/ready channels for command beats in and result beats out
// ----------------------------------------------------------------------------
interface cia_in_if import cia_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   card_id;
    logic [TYPE_W-1:0] card_type;

    modport source (output valid, output kind, output card_id, output card_type,
                    input ready);
    modport sink   (input valid, input kind, input card_id, input card_type,
                    output ready);
endinterface

interface cia_out_if import cia_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                entry_valid;
    logic [ID_W-1:0]     entry_id;
    logic [TYPE_W-1:0]   entry_type;
    logic [COUNT_W-1:0]  entry_count;
    logic                last;

    modport source (output valid, output status, output entry_valid, output entry_id,
                    output entry_type, output entry_count, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_valid, input entry_id,
                    input entry_type, input entry_count, input last,
                    output ready);
endinterface

FILE: sv/compacting_id_allowlist_top.sv
// ----------------------------------------------------------------------------
// compacting_id_allowlist_top
// card allowlist kept in a ring of record cells, compacted on remove
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  i_in     in   kind, card_id, card_type
//  o_out    out  status, entry_valid, entry_id, entry_type, entry_count, last
//
//  each accepted command runs one pass of MAX_ENTRIES ring shifts, one per
//  cycle unless a waiting result beat stalls it; ready is low until the pass ends
//  the pass length is set by the ring: every record goes once past the head cell
//  a result beat waiting in the output register stalls the ring only when the
//  next step also has a beat to give; kind 3 is taken and dropped at once
//  synchronous active-low reset empties the list; the cells themselves are not reset
// ----------------------------------------------------------------------------
module compacting_id_allowlist_top import cia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cia_in_if.sink    i_in,
    cia_out_if.source o_out
);

    t_rec w_rec [MAX_ENTRIES];
    t_rec w_tail;
    logic w_shift;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_ring
        t_rec w_feed;
        if (g == MAX_ENTRIES - 1) begin : g_tail
            assign w_feed = w_tail;
        end else begin : g_body
            assign w_feed = w_rec[g + 1];
        end
        cia_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_rec   (w_feed),
            .o_rec   (w_rec[g])
        );
    end

    cia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_head  (w_rec[0]),
        .i_next  (w_rec[NEXT_IDX]),
        .o_tail  (w_tail),
        .o_shift (w_shift)
    );

endmodule

FILE: sv/cia_cell.sv
// ----------------------------------------------------------------------------
// cia_cell
// one slot of the record ring; takes its neighbor's record on each shift
// ----------------------------------------------------------------------------
module cia_cell import cia_pkg::*; (
    input  logic i_clk,
    input  logic i_shift,
    input  t_rec i_rec,
    output t_rec o_rec
);

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

FILE: sv/cia_ctrl.sv
// ----------------------------------------------------------------------------
// cia_ctrl
// pass sequencer: watches the head cell, picks what enters the tail,
// keeps the record count and drives the result register
// ----------------------------------------------------------------------------
`include "compacting_id_allowlist_top_assert.svh"

module cia_ctrl import cia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cia_in_if.sink    i_in,
    cia_out_if.source o_out,
    input  t_rec      i_head,
    input  t_rec      i_next,
    output t_rec      o_tail,
    output logic      o_shift
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    t_state           r_state, n_state;
    t_req             r_req,   n_req;
    logic [CNT_W-1:0] r_step,  n_step;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_hit,   n_hit;
    t_res             r_out,   n_out;
    logic             r_out_valid, n_out_valid;

    logic             accept;
    logic             key_ok;
    logic             in_list;
    logic             key_hit;
    logic             hit_any;
    logic             last_step;
    logic             insert_now;
    logic             drop_now;
    logic             need_emit;
    logic             out_free;
    logic             adv;
    t_res             res;

    assign accept    = i_in.valid && i_in.ready;
    assign key_ok    = (r_req.rec.card_id != ID_NONE);
    // step s has logical entry s sitting in the head cell
    assign in_list   = (r_step < r_count);
    assign key_hit   = in_list && key_ok && (i_head.card_id == r_req.rec.card_id);
    assign hit_any   = r_hit || key_hit;
    assign last_step = (r_step == CNT_W'(MAX_ENTRIES - 1));
    assign out_free  = !r_out_valid || o_out.ready;

    // append happens when the ring slot at position count passes the tail
    assign insert_now = (r_req.kind == KIND_ADD) && (r_step == r_count) && key_ok
                        && !r_hit && (r_req.rec.card_id != ID_ALL_ONES);
    // from the matching step on, feed the tail from one cell ahead so later entries slide down
    assign drop_now   = (r_req.kind == KIND_REMOVE) && hit_any;

    always_comb begin
        if (insert_now) begin
            o_tail = r_req.rec;
        end else if (drop_now) begin
            o_tail = i_next;
        end else begin
            o_tail = i_head;
        end
    end

    always_comb begin
        res             = '0;
        res.status      = STAT_OK;
        res.entry_count = COUNT_W'(r_count);
        res.last        = 1'b1;
        n_count         = r_count;
        need_emit       = 1'b0;
        case (r_req.kind)
            KIND_ADD: begin
                need_emit = last_step;
                if (!key_ok) begin
                    res.status = STAT_INVALID;
                end else if (hit_any) begin
                    res.status = STAT_PRESENT;
                end else if (r_count >= CNT_W'(MAX_ENTRIES)) begin
                    res.status = STAT_FULL;
                end else if (r_req.rec.card_id != ID_ALL_ONES) begin
                    n_count = r_count + CNT_W'(1);
                end
                res.entry_count = COUNT_W'(n_count);
            end
            KIND_REMOVE: begin
                need_emit = last_step;
                if (!key_ok) begin
                    res.status = STAT_INVALID;
                end else if (!hit_any) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
                res.entry_count = COUNT_W'(n_count);
            end
            KIND_READ: begin
                // an empty list still gives one beat, marked not valid
                need_emit       = in_list || ((r_step == '0) && (r_count == '0));
                res.entry_valid = in_list;
                res.rec         = in_list ? i_head : '0;
                res.last        = ((r_step + CNT_W'(1)) == r_count) || (r_count == '0);
            end
            default: begin
                need_emit = 1'b0;
            end
        endcase
        if (!last_step) begin
            n_count = r_count;
        end
    end

    assign adv     = (r_state == ST_SCAN) && (!need_emit || out_free);
    assign o_shift = adv;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_step      = r_step;
        n_hit       = r_hit;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req.kind = t_kind'(i_in.kind);
                    n_req.rec  = '{card_id: i_in.card_id, card_type: i_in.card_type};
                    n_step     = '0;
                    n_hit      = 1'b0;
                    if (t_kind'(i_in.kind) != KIND_UNUSED) begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (adv) begin
                    n_step = r_step + CNT_W'(1);
                    n_hit  = hit_any;
                    if (need_emit) begin
                        n_out       = res;
                        n_out_valid = 1'b1;
                    end
                    if (last_step) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_hit       <= n_hit;
            if (adv) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_out <= n_out;
    end

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.entry_valid = r_out.entry_valid;
    assign o_out.entry_id    = r_out.rec.card_id;
    assign o_out.entry_type  = r_out.rec.card_type;
    assign o_out.entry_count = r_out.entry_count;
    assign o_out.last        = r_out.last;

    `CIA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_ENTRIES))
    `CIA_ASSERT_NEXT(a_pass_ends, i_clk, i_rst_n, adv && last_step, r_state == ST_IDLE)
    `CIA_ASSERT_NEXT(a_count_at_end, i_clk, i_rst_n, !(adv && last_step), $stable(r_count))
    `CIA_ASSERT_NOW(a_no_emit_idle, i_clk, i_rst_n, r_state == ST_IDLE, !o_shift)

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the card allowlist: command beats go in with random
// gaps, result beats are taken with random stalls and matched in order against
// a shadow copy of the list kept inside the bench
// ----------------------------------------------------------------------------
module tb_top;
    import cia_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_SHOWN = 10;
    localparam int ID_POOL_SIZE = 24;

    logic i_clk;
    logic i_rst_n;

    cia_in_if  u_in_if ();
    cia_out_if u_out_if ();

    compacting_id_allowlist_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    // shadow copy of the allowlist
    logic [ID_W-1:0]   shadow_ids   [MAX_ENTRIES];
    logic [TYPE_W-1:0] shadow_types [MAX_ENTRIES];
    int                shadow_count;

    t_res              pending_results [$];
    logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];
    int                mismatch_cnt = 0;
    int                cycle_cnt = 0;
    bit                calm;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #HALF_PERIOD i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void push_result(t_status st, logic ev, logic [ID_W-1:0] id,
                                        logic [TYPE_W-1:0] ty, logic lst);
        t_res r;
        r.status         = st;
        r.entry_valid    = ev;
        r.rec.card_id    = id;
        r.rec.card_type  = ty;
        r.entry_count    = COUNT_W'(shadow_count);
        r.last           = lst;
        pending_results.push_back(r);
    endfunction

    // apply one accepted command to the shadow list and queue its result beats
    function automatic void allowlist_predict(t_kind kind, logic [ID_W-1:0] id,
                                              logic [TYPE_W-1:0] ctype);
        int hit;
        t_status st;
        hit = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (hit < 0 && shadow_ids[i] == id) hit = i;
        end
        case (kind)
            KIND_ADD: begin
                if (id == ID_NONE) begin
                    st = STAT_INVALID;
                end else if (hit >= 0) begin
                    st = STAT_PRESENT;
                end else if (shadow_count >= MAX_ENTRIES) begin
                    st = STAT_FULL;
                end else begin
                    st = STAT_OK;
                    // all-ones id reports ok but never lands in the list
                    if (id != ID_ALL_ONES) begin
                        shadow_ids[shadow_count]   = id;
                        shadow_types[shadow_count] = ctype;
                        shadow_count++;
                    end
                end
                push_result(st, 1'b0, '0, '0, 1'b1);
            end
            KIND_REMOVE: begin
                if (id == ID_NONE) begin
                    st = STAT_INVALID;
                end else if (hit < 0) begin
                    st = STAT_NOT_FOUND;
                end else begin
                    st = STAT_OK;
                    for (int i = hit; i + 1 < shadow_count; i++) begin
                        shadow_ids[i]   = shadow_ids[i+1];
                        shadow_types[i] = shadow_types[i+1];
                    end
                    shadow_count--;
                end
                push_result(st, 1'b0, '0, '0, 1'b1);
            end
            KIND_READ: begin
                if (shadow_count == 0) begin
                    push_result(STAT_OK, 1'b0, '0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        push_result(STAT_OK, 1'b1, shadow_ids[i], shadow_types[i],
                                    (i == shadow_count - 1));
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_cmd(t_kind kind, logic [ID_W-1:0] id, logic [TYPE_W-1:0] ctype);
        int gap;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            u_in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        u_in_if.valid     <= 1'b1;
        u_in_if.kind      <= kind;
        u_in_if.card_id   <= id;
        u_in_if.card_type <= ctype;
        do @(posedge i_clk); while (!u_in_if.ready);
        allowlist_predict(kind, id, ctype);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // sender holds off until every queued result beat has been taken
    task automatic pause_until_drained();
        @(negedge i_clk);
        u_in_if.valid <= 1'b0;
        wait_drained();
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return ID_NONE;
        if (r < 10) return ID_ALL_ONES;
        if (r < 50 && shadow_count > 0) return shadow_ids[$urandom_range(0, shadow_count - 1)];
        if (r < 85) return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stalls on ready, in-order compare on every beat
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        u_out_if.ready = 1'b0;
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                @(negedge i_clk);
                u_out_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            u_out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(u_out_if.valid && u_out_if.ready));
        end
    end

    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            got.status        = t_status'(u_out_if.status);
            got.entry_valid   = u_out_if.entry_valid;
            got.rec.card_id   = u_out_if.entry_id;
            got.rec.card_type = u_out_if.entry_type;
            got.entry_count   = u_out_if.entry_count;
            got.last          = u_out_if.last;
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                    $display("unexpected beat: st=%0d ev=%0b id=%08h ty=%02h cnt=%0d last=%0b",
                             got.status, got.entry_valid, got.rec.card_id,
                             got.rec.card_type, got.entry_count, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status || got.entry_valid != want.entry_valid ||
                    got.rec.card_id != want.rec.card_id ||
                    got.rec.card_type != want.rec.card_type ||
                    got.entry_count != want.entry_count || got.last != want.last) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN) begin
                        $display("result mismatch at cycle %0d", cycle_cnt);
                        $display("  exp st=%0d ev=%0b id=%08h ty=%02h cnt=%0d last=%0b",
                                 want.status, want.entry_valid, want.rec.card_id,
                                 want.rec.card_type, want.entry_count, want.last);
                        $display("  got st=%0d ev=%0b id=%08h ty=%02h cnt=%0d last=%0b",
                                 got.status, got.entry_valid, got.rec.card_id,
                                 got.rec.card_type, got.entry_count, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_empty_list();
        send_cmd(KIND_READ, $urandom, 8'($urandom_range(0, 255)));
        send_cmd(KIND_REMOVE, ID_NONE, 8'hA5);
        send_cmd(KIND_ADD, ID_NONE, 8'hFF);
        // all-ones is acknowledged but not kept, so its removal misses
        send_cmd(KIND_ADD, ID_ALL_ONES, 8'h00);
        send_cmd(KIND_REMOVE, ID_ALL_ONES, 8'h00);
        send_cmd(KIND_REMOVE, 32'h0000_0001, 8'h00);
    endtask

    task automatic test_fill_to_capacity();
        logic [ID_W-1:0] edge_ids [4];
        logic [ID_W-1:0] id;
        edge_ids = '{32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF};
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            id = (i < 4) ? edge_ids[i] : {4'(i), 28'($urandom)};
            send_cmd(KIND_ADD, id, (i < 2) ? {TYPE_W{i[0]}} : 8'($urandom));
        end
        send_cmd(KIND_ADD, shadow_ids[5], 8'h3C);
        send_cmd(KIND_ADD, 32'h0000_0002, 8'h11);
        send_cmd(KIND_ADD, ID_ALL_ONES, 8'h22);
        send_cmd(KIND_READ, 32'h0, 8'h0);
        send_cmd(KIND_REMOVE, shadow_ids[0], 8'h0);
        send_cmd(KIND_REMOVE, shadow_ids[shadow_count - 1], 8'h0);
        send_cmd(KIND_UNUSED, $urandom, 8'($urandom));
    endtask

    // kind 3 beats ride along but are not counted
    task automatic test_random_churn(int n, int add_pct, int rem_pct);
        int done;
        int r;
        done = 0;
        while (done < n) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                send_cmd(KIND_ADD, pick_id(), 8'($urandom));
                done++;
            end else if (r < add_pct + rem_pct) begin
                send_cmd(KIND_REMOVE, pick_id(), 8'($urandom));
                done++;
            end else if (r < 96) begin
                send_cmd(KIND_READ, $urandom, 8'($urandom));
                done++;
            end else begin
                send_cmd(KIND_UNUSED, $urandom, 8'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        u_in_if.valid     = 1'b0;
        u_in_if.kind      = KIND_ADD;
        u_in_if.card_id   = '0;
        u_in_if.card_type = '0;
        shadow_count      = 0;
        calm              = 1'b0;
        for (int i = 0; i < ID_POOL_SIZE; i++) id_pool[i] = $urandom;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_capacity();
        test_random_churn(70, 70, 20);
        pause_until_drained();
        calm = 1'b1;
        test_random_churn(35, 40, 40);
        calm = 1'b0;
        test_random_churn(70, 15, 65);
        pause_until_drained();
        test_random_churn(60, 45, 40);

        @(negedge i_clk);
        u_in_if.valid <= 1'b0;
        wait_drained();
        repeat (MAX_ENTRIES + 4) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
